/* rtl/pop_pkg.sv */
`timescale 1ns / 1ps
package pop_pkg;

	localparam int unsigned PRICE_W  = 32;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned BASKET_W = 50;
	localparam int unsigned SUM_W    = 34;
	localparam int unsigned RATIO_W  = 24;
	localparam int unsigned STEP_W   = 10;
	localparam int unsigned ASSET_W  = 3;
	localparam int unsigned PAY_W    = 17;
	localparam int unsigned LANES    = 4;
	localparam int unsigned ITER_W   = 6;

	localparam logic [PAY_W-1:0]   ONE_Q16   = 17'd65536;
	localparam logic [SUM_W-1:0]   ONE_SUM   = 34'd65536;
	localparam logic [SUM_W-1:0]   TENTH_SUM = 34'd6554;
	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [ITER_W-1:0]  RATIO_ITERS = 6'd24;
	localparam logic [ITER_W-1:0]  AVG_ITERS   = 6'd34;

	// register indexes of the configuration port
	localparam logic [2:0] REG_WEIGHT_A = 3'd0;
	localparam logic [2:0] REG_WEIGHT_B = 3'd1;
	localparam logic [2:0] REG_WEIGHT_C = 3'd2;
	localparam logic [2:0] REG_WEIGHT_D = 3'd3;
	localparam logic [2:0] REG_STEPS    = 3'd4;
	localparam logic [2:0] REG_ASSETS   = 3'd5;

	typedef struct packed {
		logic [PRICE_W-1:0] price_a;
		logic [PRICE_W-1:0] price_b;
		logic [PRICE_W-1:0] price_c;
		logic [PRICE_W-1:0] price_d;
		logic               path_start;
	} in_word_t;

	typedef struct packed {
		logic [PAY_W-1:0] payoff_value;
		logic             divide_error;
	} out_word_t;

	typedef struct packed {
		logic                start;
		logic [BASKET_W-1:0] rem_init;
		logic [SUM_W-1:0]    dividend;
		logic [ITER_W-1:0]   iters;
		logic [BASKET_W-1:0] den;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RATIO,
		ST_DIV,
		ST_AVG,
		ST_AVG_WAIT,
		ST_EMIT
	} state_t;

endpackage

/* rtl/pop_basket_mac.sv */
`timescale 1ns / 1ps
// weighted basket, one weight bit of every lane per cycle, msb first
module pop_basket_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [pop_pkg::LANES-1:0][pop_pkg::PRICE_W-1:0]  prices,
	input  logic [pop_pkg::LANES-1:0][pop_pkg::WEIGHT_W-1:0] weights,
	output logic                                   done,
	output logic [pop_pkg::BASKET_W-1:0]           basket
);
	logic [pop_pkg::LANES-1:0][pop_pkg::PRICE_W-1:0]  price_q;
	logic [pop_pkg::LANES-1:0][pop_pkg::WEIGHT_W-1:0] wsh_q;
	logic [pop_pkg::BASKET_W-1:0] acc_q;
	logic [4:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [pop_pkg::PRICE_W+1:0]  psum;

	// sum of the lane prices selected by the current weight bit
	always_comb begin
		psum = '0;
		for (int i = 0; i < pop_pkg::LANES; i++) begin
			if (wsh_q[i][pop_pkg::WEIGHT_W-1]) begin
				psum = psum + {2'b00, price_q[i]};
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(pop_pkg::WEIGHT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			price_q <= prices;
			wsh_q   <= weights;
			acc_q   <= '0;
		end else if (busy_q) begin
			for (int i = 0; i < pop_pkg::LANES; i++) begin
				wsh_q[i] <= {wsh_q[i][pop_pkg::WEIGHT_W-2:0], 1'b0};
			end
			acc_q <= {acc_q[pop_pkg::BASKET_W-2:0], 1'b0}
				+ {{(pop_pkg::BASKET_W-pop_pkg::PRICE_W-2){1'b0}}, psum};
		end
	end

	assign done   = done_q;
	assign basket = acc_q;
endmodule

/* rtl/pop_divider.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, shared by ratio and average
module pop_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pop_pkg::div_req_t           req,
	output logic                        done,
	output logic [pop_pkg::SUM_W-1:0]   quot
);
	logic [pop_pkg::BASKET_W-1:0] rem_q;
	logic [pop_pkg::BASKET_W-1:0] den_q;
	logic [pop_pkg::SUM_W-1:0]    dvd_q;
	logic [pop_pkg::SUM_W-1:0]    quot_q;
	logic [pop_pkg::ITER_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [pop_pkg::BASKET_W:0]   trial;
	logic                         fits;

	// bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[pop_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			den_q  <= req.den;
			dvd_q  <= req.dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[pop_pkg::SUM_W-2:0], 1'b0};
			quot_q <= {quot_q[pop_pkg::SUM_W-2:0], fits};
			if (fits) begin
				rem_q <= pop_pkg::BASKET_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[pop_pkg::BASKET_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

/* rtl/performance_option_payoff_core.sv */
`timescale 1ns / 1ps
// Performance option payoff core.
// Input channel in_valid / in_stall / in_word carries one price row per word
// (four Q16.16 prices and a path start flag). The core takes one row at a
// time and holds in_stall high while it works on it.
// Per row: shift-and-add basket formation (one weight bit per cycle), a
// hand-over to the step checks, then the bit-serial divider for the
// day-over-day ratio. A path start row ends after the basket; a step with a
// zero denominator or a saturated ratio skips the divider. A row that closes
// a path then has the divider form the average, collects it and loads the
// output register.
// Output channel out_valid / out_stall / out_word carries the Q1.16 payoff
// and the zero-denominator flag; a result sits in an output register, so
// the next row is taken while out_stall holds it. With the output register
// still full, a new result waits in the core until it drains.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the core is idle. Reset clears the path
// state and returns every weight to 4096, step count to 1 and the lane count to 4.
module performance_option_payoff_core #(
	parameter int unsigned MAX_ASSETS = 4,
	parameter int unsigned MAX_STEPS  = 1023
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pop_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output pop_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	pop_pkg::state_t state_q, state_d;

	logic [pop_pkg::WEIGHT_W-1:0] weight_q [pop_pkg::LANES];
	logic [pop_pkg::STEP_W-1:0]   steps_cfg_q;
	logic [pop_pkg::ASSET_W-1:0]  assets_q;

	logic [pop_pkg::BASKET_W-1:0] prev_q;
	logic [pop_pkg::BASKET_W-1:0] today_q;
	logic [pop_pkg::SUM_W-1:0]    sum_q;
	logic [pop_pkg::STEP_W-1:0]   row_q;
	logic                         err_q;
	logic                         start_q;
	logic                         out_valid_q;
	pop_pkg::out_word_t           out_q;

	logic                         in_take;
	logic                         mac_done;
	logic [pop_pkg::BASKET_W-1:0] basket;
	logic                         div_done;
	logic [pop_pkg::SUM_W-1:0]    quot;
	pop_pkg::div_req_t            div_req;
	logic [pop_pkg::LANES-1:0][pop_pkg::PRICE_W-1:0]  lane_price;
	logic [pop_pkg::LANES-1:0][pop_pkg::WEIGHT_W-1:0] lane_weight;
	logic [pop_pkg::ASSET_W-1:0]  lanes_used;
	logic [pop_pkg::STEP_W-1:0]   steps;
	logic                         den_zero;
	logic                         ratio_sat;
	logic [pop_pkg::SUM_W:0]      sum_add;
	logic [pop_pkg::SUM_W-1:0]    sum_next;
	logic [pop_pkg::SUM_W-1:0]    perf;
	logic                         slot_free;
	logic                         last_row;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != pop_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pop_pkg::LANES; i++) begin
				weight_q[i] <= 16'd4096;
			end
			steps_cfg_q <= 10'd1;
			assets_q    <= 3'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pop_pkg::REG_WEIGHT_A: weight_q[0] <= cfg_data;
				pop_pkg::REG_WEIGHT_B: weight_q[1] <= cfg_data;
				pop_pkg::REG_WEIGHT_C: weight_q[2] <= cfg_data;
				pop_pkg::REG_WEIGHT_D: weight_q[3] <= cfg_data;
				pop_pkg::REG_STEPS:    steps_cfg_q <= cfg_data[pop_pkg::STEP_W-1:0];
				pop_pkg::REG_ASSETS:   assets_q <= cfg_data[pop_pkg::ASSET_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped lane and step counts
	always_comb begin
		lanes_used = assets_q;
		if (lanes_used == '0) begin
			lanes_used = 3'd1;
		end
		if (32'(lanes_used) > MAX_ASSETS) begin
			lanes_used = pop_pkg::ASSET_W'(MAX_ASSETS);
		end
		steps = steps_cfg_q;
		if (steps == '0) begin
			steps = 10'd1;
		end
		if (32'(steps) > MAX_STEPS) begin
			steps = pop_pkg::STEP_W'(MAX_STEPS);
		end
	end

	// lanes outside the basket enter the multiplier as zero
	always_comb begin
		lane_price[0] = in_word.price_a;
		lane_price[1] = in_word.price_b;
		lane_price[2] = in_word.price_c;
		lane_price[3] = in_word.price_d;
		for (int i = 0; i < pop_pkg::LANES; i++) begin
			lane_weight[i] = weight_q[i];
			if (3'(i) >= lanes_used) begin
				lane_price[i] = '0;
			end
		end
	end

	pop_basket_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_take),
		.prices  (lane_price),
		.weights (lane_weight),
		.done    (mac_done),
		.basket  (basket)
	);

	// step checks and ratio accumulation
	assign den_zero  = (prev_q == '0);
	assign ratio_sat = {8'd0, today_q} >= {prev_q, 8'd0};
	always_comb begin
		if (state_q == pop_pkg::ST_RATIO) begin
			sum_add = {1'b0, sum_q} + {11'd0, pop_pkg::RATIO_MAX};
		end else begin
			sum_add = {1'b0, sum_q} + {11'd0, quot[pop_pkg::RATIO_W-1:0]};
		end
		sum_next = sum_add[pop_pkg::SUM_W] ? pop_pkg::SUM_MAX : sum_add[pop_pkg::SUM_W-1:0];
	end
	assign last_row = (row_q >= steps);

	// performance clamp of the average
	always_comb begin
		if (quot > pop_pkg::ONE_SUM) begin
			perf = quot - pop_pkg::ONE_SUM;
		end else begin
			perf = '0;
		end
		if (perf > pop_pkg::TENTH_SUM) begin
			perf = pop_pkg::TENTH_SUM;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pop_pkg::ST_IDLE:     if (in_take) state_d = pop_pkg::ST_MUL;
			pop_pkg::ST_MUL: begin
				if (mac_done) begin
					state_d = start_q ? pop_pkg::ST_IDLE : pop_pkg::ST_RATIO;
				end
			end
			pop_pkg::ST_RATIO: begin
				if (den_zero || ratio_sat) begin
					state_d = pop_pkg::ST_AVG;
				end else begin
					state_d = pop_pkg::ST_DIV;
				end
			end
			pop_pkg::ST_DIV:      if (div_done) state_d = pop_pkg::ST_AVG;
			pop_pkg::ST_AVG:      state_d = last_row ? pop_pkg::ST_AVG_WAIT : pop_pkg::ST_IDLE;
			pop_pkg::ST_AVG_WAIT: if (div_done) state_d = pop_pkg::ST_EMIT;
			pop_pkg::ST_EMIT:     if (slot_free) state_d = pop_pkg::ST_IDLE;
			default:              state_d = pop_pkg::ST_IDLE;
		endcase
	end

	// divider requests
	always_comb begin
		div_req = '0;
		unique case (state_q)
			pop_pkg::ST_RATIO: begin
				div_req.start    = !den_zero && !ratio_sat;
				div_req.rem_init = {8'd0, today_q[pop_pkg::BASKET_W-1:8]};
				div_req.dividend = {today_q[7:0], 26'd0};
				div_req.iters    = pop_pkg::RATIO_ITERS;
				div_req.den      = prev_q;
			end
			pop_pkg::ST_AVG: begin
				div_req.start    = last_row;
				div_req.rem_init = '0;
				div_req.dividend = sum_q;
				div_req.iters    = pop_pkg::AVG_ITERS;
				div_req.den      = {40'd0, steps};
			end
			default: div_req = '0;
		endcase
	end

	pop_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pop_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			today_q <= '0;
			sum_q   <= '0;
			row_q   <= '0;
			err_q   <= 1'b0;
			start_q <= 1'b0;
		end else begin
			if (in_take) begin
				start_q <= in_word.path_start;
			end
			unique case (state_q)
				pop_pkg::ST_MUL: begin
					if (mac_done) begin
						today_q <= basket;
						if (start_q) begin
							prev_q <= basket;
							sum_q  <= '0;
							row_q  <= '0;
							err_q  <= 1'b0;
						end
					end
				end
				pop_pkg::ST_RATIO: begin
					row_q  <= row_q + 10'd1;
					prev_q <= today_q;
					if (den_zero) begin
						err_q <= 1'b1;
					end else if (ratio_sat) begin
						sum_q <= sum_next;
					end
				end
				pop_pkg::ST_DIV: begin
					if (div_done) begin
						sum_q <= sum_next;
					end
				end
				pop_pkg::ST_EMIT: begin
					if (slot_free) begin
						sum_q <= '0;
						row_q <= '0;
						err_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pop_pkg::ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// the average stays in the divider until the output register is free
	always_ff @(posedge clk) begin
		if (state_q == pop_pkg::ST_EMIT && slot_free) begin
			out_q.payoff_value <= pop_pkg::ONE_Q16 + perf[pop_pkg::PAY_W-1:0];
			out_q.divide_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
endmodule
